// File: hdl/sar_pkg.sv
// Shared constants and codes for the sample average filter with step restart.
`default_nettype none

package sar_pkg;

  // Field widths fixed by the item format
  localparam int OPCODE_W  = 2;
  localparam int THR_W     = 12;
  localparam int RUN_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;

  // Item opcodes
  localparam logic [OPCODE_W-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RECOMPUTE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESPOND   = 2'd2;

  // Register reset values
  localparam logic [THR_W-1:0] THRESHOLD_RST = 12'd100;
  localparam logic [RUN_W-1:0] RESPOND_RST   = 8'd3;

endpackage : sar_pkg

`default_nettype wire

// File: hdl/sar_ring.sv
// Sample ring buffer: one write port, one read port with registered data.
`default_nettype none

module sar_ring #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 12,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : sar_ring

`default_nettype wire

// File: hdl/sar_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module sar_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic      [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic              qbit;
  logic [DEN_W-1:0]  rem_next;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial    = {rem, quotient[NUM_W-1]};
    qbit     = (trial >= {1'b0, divisor});
    rem_next = qbit ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
  end

  // Iteration control; dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (steps == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      steps    <= STEP_W'(NUM_W);
    end else if (busy) begin
      quotient <= {quotient[NUM_W-2:0], qbit};
      rem      <= rem_next;
      steps    <= steps - STEP_W'(1);
    end
  end

endmodule : sar_div

`default_nettype wire

// File: hdl/sample_average_with_step_reset_core.sv
// Top level: sample ring filter with step restart and sequenced average recompute.
//
//  channel | dir | fields (lowest bit first)
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tuser: opcode; tdata: sample
//  m_*     | out | tdata: average, fill_count, step_restart, accepted
//  cfg_*   | in  | cfg_index selects enable / step_threshold / respond_count
//
//  Sample, clear and unknown opcodes finish in the accept cycle; the result
//  shows in the output register on the next cycle.
//  Recompute of a non-empty ring reads fill_count ring entries, one per cycle,
//  into the accumulator, then takes one quotient bit per cycle from the
//  divider. The input is not ready during that time.
//  A new item is taken only when the output register is empty or draining.
//  Reset (rst, synchronous) empties the ring by zeroing the fill count.
`default_nettype none

module sample_average_with_step_reset_core #(
  parameter int BUFFER_DEPTH = 16,
  parameter int SAMPLE_BITS  = 12,
  localparam int CNT_W      = $clog2(BUFFER_DEPTH + 1),
  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_RAW_W  = SAMPLE_BITS + CNT_W + 2,
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input items
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [IN_DATA_W-1:0]           s_tdata,  // sample
  input  wire logic [sar_pkg::OPCODE_W-1:0]   s_tuser,  // opcode
  // results
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [OUT_DATA_W-1:0]          m_tdata,  // average, fill_count,
                                                        // step_restart, accepted
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sar_pkg::CFG_W-1:0]      cfg_data
);

  import sar_pkg::*;

  localparam int IDX_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int CMP_W       = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int RESTART_IDX = 1 % BUFFER_DEPTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // Configuration registers
  logic             enable;
  logic [THR_W-1:0] step_threshold;
  logic [RUN_W-1:0] respond_count;

  // Filter state
  logic [1:0]             state;
  logic [IDX_W-1:0]       write_index;
  logic [CNT_W-1:0]       filled;
  logic [SAMPLE_BITS-1:0] held_average;
  logic [RUN_W-1:0]       step_run;

  // Recompute sequencer
  logic [CNT_W-1:0] rd_count;
  logic             rd_pending;
  logic [SUM_W-1:0] acc;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quotient;

  // Result register
  logic                   res_valid;
  logic                   res_load;
  logic [SAMPLE_BITS-1:0] res_average;
  logic [CNT_W-1:0]       res_fill;
  logic                   res_restart;
  logic                   res_accepted;

  // Ring ports
  logic                   ring_wr_en;
  logic [IDX_W-1:0]       ring_wr_addr;
  logic [SAMPLE_BITS-1:0] ring_rd_data;

  // Accept-cycle decode
  logic                   out_free;
  logic                   in_fire;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] diff;
  logic                   is_step;
  logic                   do_restart;
  logic                   go_sum;
  logic                   accepted_now;
  logic [IDX_W-1:0]       write_index_next;
  logic [CNT_W-1:0]       filled_next;
  logic [SAMPLE_BITS-1:0] held_average_next;
  logic [RUN_W-1:0]       step_run_next;
  logic [IDX_W-1:0]       index_inc;
  logic                   rd_issue;

  assign out_free  = !res_valid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = res_valid;
  assign m_tdata   = OUT_DATA_W'({res_accepted, res_restart, res_fill, res_average});

  assign smp       = s_tdata[SAMPLE_BITS-1:0];
  assign index_inc = (write_index == IDX_W'(BUFFER_DEPTH - 1)) ? '0
                                                               : write_index + IDX_W'(1);

  // Step detection against the held average
  always_comb begin
    diff       = (smp >= held_average) ? smp - held_average : held_average - smp;
    is_step    = CMP_W'(diff) >= CMP_W'(step_threshold);
    do_restart = is_step && (step_run >= respond_count);
  end

  // Next state for items that finish in the accept cycle
  always_comb begin
    write_index_next  = write_index;
    filled_next       = filled;
    held_average_next = held_average;
    step_run_next     = step_run;
    accepted_now      = 1'b1;
    go_sum            = 1'b0;
    ring_wr_en        = 1'b0;
    ring_wr_addr      = write_index;
    case (s_tuser)
      OP_SAMPLE: begin
        if (!enable) begin
          accepted_now = 1'b0;
        end else begin
          ring_wr_en = 1'b1;
          if (do_restart) begin
            ring_wr_addr      = '0;
            write_index_next  = IDX_W'(RESTART_IDX);
            filled_next       = CNT_W'(1);
            held_average_next = smp;
          end else begin
            write_index_next = index_inc;
            if (filled != CNT_W'(BUFFER_DEPTH)) begin
              filled_next = filled + CNT_W'(1);
            end
            step_run_next = is_step ? step_run + RUN_W'(1) : '0;
          end
        end
      end
      OP_RECOMPUTE: begin
        if (filled == '0) begin
          held_average_next = '0;
        end else begin
          go_sum = 1'b1;
        end
      end
      OP_CLEAR: begin
        write_index_next  = '0;
        filled_next       = '0;
        held_average_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      step_threshold <= THRESHOLD_RST;
      respond_count  <= RESPOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:    enable         <= cfg_data[0];
        REG_THRESHOLD: step_threshold <= cfg_data[THR_W-1:0];
        REG_RESPOND:   respond_count  <= cfg_data[RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign rd_issue  = (state == ST_SUM) && (rd_count != filled);
  assign div_start = (state == ST_SUM) && (rd_count == filled) && !rd_pending;

  // Result register loads on a finished item, otherwise drains on ready
  assign res_load = (in_fire && !go_sum) || ((state == ST_OUT) && out_free);

  // Sequencer, filter state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_index  <= '0;
      filled       <= '0;
      held_average <= '0;
      step_run     <= '0;
      res_valid    <= 1'b0;
      rd_pending   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
      rd_pending <= rd_issue;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            write_index  <= write_index_next;
            filled       <= filled_next;
            held_average <= held_average_next;
            step_run     <= step_run_next;
            if (go_sum) begin
              state <= ST_SUM;
            end else begin
              res_average  <= held_average_next;
              res_fill     <= filled_next;
              res_restart  <= (s_tuser == OP_SAMPLE) && enable && do_restart;
              res_accepted <= accepted_now;
            end
          end
        end
        ST_SUM: begin
          if (div_start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            held_average <= div_quotient[SAMPLE_BITS-1:0];
            res_average  <= div_quotient[SAMPLE_BITS-1:0];
            res_fill     <= filled;
            res_restart  <= 1'b0;
            res_accepted <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Read address counter and accumulator for the recompute sum
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rd_count <= '0;
      acc      <= '0;
    end else begin
      if (rd_issue) begin
        rd_count <= rd_count + CNT_W'(1);
      end
      if (rd_pending) begin
        acc <= acc + SUM_W'(ring_rd_data);
      end
    end
  end

  sar_ring #(
    .DEPTH (BUFFER_DEPTH),
    .WIDTH (SAMPLE_BITS),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (in_fire && ring_wr_en),
    .wr_addr (ring_wr_addr),
    .wr_data (smp),
    .rd_addr (rd_count[IDX_W-1:0]),
    .rd_data (ring_rd_data)
  );

  sar_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (filled),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule : sample_average_with_step_reset_core

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the sample average filter with step restart.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sar_pkg::*;

  localparam int DEPTH       = 16;
  localparam int SMP_W       = 12;
  localparam int CNT_W       = 5;
  localparam int IN_W        = 16;
  localparam int OUT_W       = 24;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SMP_MAX     = (1 << SMP_W) - 1;

  // Opcode with no defined action; the block must pass it through untouched
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // Result fields, lowest bit last in the declaration
  typedef struct packed {
    logic             accepted;
    logic             step_restart;
    logic [CNT_W-1:0] fill_count;
    logic [SMP_W-1:0] average;
  } filter_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic [OPCODE_W-1:0]  s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  sample_average_with_step_reset_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Filter state mirrored by the predictor
  logic [SMP_W-1:0] ring_q [DEPTH];
  logic [3:0]       wr_ptr;
  logic [CNT_W-1:0] fill_q;
  logic [SMP_W-1:0] avg_q;
  logic [7:0]       step_run_q;
  logic             en_q;
  logic [11:0]      thr_q;
  logic [7:0]       respond_q;

  filter_out_t expected_results [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic void clear_ring();
    foreach (ring_q[i]) ring_q[i] = '0;
    wr_ptr = '0;
    fill_q = '0;
    avg_q  = '0;
  endfunction

  // Apply one item to the mirrored state and return the result it produces
  function automatic filter_out_t filter_predict(logic [OPCODE_W-1:0] op,
                                                 logic [SMP_W-1:0] smp);
    filter_out_t res;
    logic [SMP_W-1:0] diff;
    int unsigned sum;
    res.step_restart = 1'b0;
    res.accepted     = 1'b1;
    case (op)
      OP_SAMPLE: begin
        if (!en_q) begin
          res.accepted = 1'b0;
        end else begin
          ring_q[wr_ptr] = smp;
          wr_ptr = wr_ptr + 4'd1;
          if (fill_q < DEPTH) fill_q = fill_q + 1'b1;
          diff = (smp > avg_q) ? smp - avg_q : avg_q - smp;
          if (diff >= thr_q) begin
            if (step_run_q >= respond_q) begin
              // step held long enough: restart the ring from this sample
              foreach (ring_q[i]) ring_q[i] = '0;
              ring_q[0] = smp;
              wr_ptr = 4'd1;
              fill_q = 5'd1;
              avg_q  = smp;
              res.step_restart = 1'b1;
            end else begin
              step_run_q = step_run_q + 8'd1;
            end
          end else begin
            step_run_q = '0;
          end
        end
      end
      OP_RECOMPUTE: begin
        if (fill_q == 0) begin
          avg_q = '0;
        end else begin
          sum = 0;
          for (int i = 0; i < fill_q; i++) sum += ring_q[i];
          avg_q = SMP_W'(sum / fill_q);
        end
      end
      OP_CLEAR: clear_ring();
      default: ;
    endcase
    res.average    = avg_q;
    res.fill_count = fill_q;
    return res;
  endfunction

  // Free-running cycle count with a hard stop
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    filter_out_t got;
    filter_out_t exp;
    if (!rst && m_tvalid && m_tready) begin
      got = filter_out_t'(m_tdata[$bits(filter_out_t)-1:0]);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result avg=%0d fill=%0d restart=%0b acc=%0b",
                   got.average, got.fill_count, got.step_restart, got.accepted);
      end else begin
        exp = expected_results.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch exp avg=%0d fill=%0d restart=%0b acc=%0b",
                   exp.average, exp.fill_count, exp.step_restart, exp.accepted);
            $display(" | got avg=%0d fill=%0d restart=%0b acc=%0b",
                     got.average, got.fill_count, got.step_restart, got.accepted);
          end
        end
      end
    end
  end

  // Send one item; entered and left at a falling edge
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SMP_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = IN_W'(smp);
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(filter_predict(op, smp));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Hold off input until every outstanding result has been returned
  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:    en_q = val[0];
      REG_THRESHOLD: thr_q = val[11:0];
      REG_RESPOND:   respond_q = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Unused upper data bits are filled with noise; the block keeps the low bits
  task automatic configure(input logic en, input logic [11:0] thr, input logic [7:0] resp);
    write_reg(REG_ENABLE, {11'($urandom), en});
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_RESPOND, {4'($urandom), resp});
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  // Power-up defaults: disabled, so samples drop but other opcodes still act
  task automatic test_after_reset();
    set_idle_mode(0);
    send_item(OP_SAMPLE, 12'hFFF);
    send_item(OP_RECOMPUTE, 12'h000);
    send_item(OP_UNUSED, 12'hABC);
    send_item(OP_CLEAR, 12'h555);
    wait_drained();
  endtask

  // Step restart, run counter kept across restart and clear, extremes
  task automatic test_step_restart();
    configure(1'b1, 12'd100, 8'd3);
    send_item(OP_SAMPLE, 12'd0);
    repeat (4) send_item(OP_SAMPLE, 12'hFFF);   // fourth step restarts
    send_item(OP_SAMPLE, 12'd4000);             // inside threshold, run drops
    send_item(OP_RECOMPUTE, 12'd0);
    repeat (2) send_item(OP_SAMPLE, 12'd0);
    send_item(OP_CLEAR, 12'd0);
    repeat (2) send_item(OP_SAMPLE, 12'hFFF);   // run survives the clear
    send_item(OP_UNUSED, 12'hFFF);
    send_item(OP_RECOMPUTE, 12'd0);
    send_item(OP_SAMPLE, 12'hAAA);
    send_item(OP_SAMPLE, 12'h555);
    write_reg(REG_ENABLE, 12'd0);
    send_item(OP_SAMPLE, 12'd7);                // dropped with a filled ring
    send_item(OP_RECOMPUTE, 12'd0);
    wait_drained();
  endtask

  // Random traffic: a level with noise, occasional jumps to force step runs
  task automatic test_random_phase(input logic en, input logic [11:0] thr,
                                   input logic [7:0] resp, input int mode,
                                   input int n_items);
    int level;
    int span;
    int smp;
    int pick;
    int sent;
    logic [OPCODE_W-1:0] op;
    configure(en, thr, resp);
    set_idle_mode(mode);
    level = $urandom_range(SMP_MAX);
    span  = (thr > 8) ? (thr * 3) / 4 : 8;
    sent  = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      op   = OP_SAMPLE;
      smp  = 0;
      if ($urandom_range(99) < 8) level = $urandom_range(SMP_MAX);
      if (pick < 62) begin
        smp = level + $urandom_range(2 * span) - span;
        if (smp < 0) smp = 0;
        if (smp > SMP_MAX) smp = SMP_MAX;
      end else if (pick < 72) begin
        smp = $urandom_range(SMP_MAX);
      end else if (pick < 86) begin
        op = OP_RECOMPUTE;
      end else if (pick < 91) begin
        op = OP_CLEAR;
      end else if (pick < 95) begin
        op = OP_UNUSED;
        smp = $urandom_range(SMP_MAX);
      end else begin
        smp = $urandom_range(1) ? SMP_MAX : 0;
      end
      send_item(op, SMP_W'(smp));
      sent++;
      if ($urandom_range(99) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    clear_ring();
    step_run_q = '0;
    en_q       = 1'b0;
    thr_q      = THRESHOLD_RST;
    respond_q  = RESPOND_RST;

    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_after_reset();
    test_step_restart();
    test_random_phase(1'b1, 12'd100, 8'd3, 0, 150);
    test_random_phase(1'b1, 12'd0, 8'd0, 1, 150);
    test_random_phase(1'b1, 12'd4095, 8'd255, 2, 150);
    test_random_phase(1'b1, 12'($urandom_range(1, 400)), 8'($urandom_range(8)), 3, 150);
    test_random_phase(1'b0, 12'($urandom), 8'($urandom), 0, 30);
    test_random_phase(1'b1, 12'd300, 8'd1, 1, 150);
    test_random_phase(1'b1, 12'($urandom), 8'($urandom), 2, 150);
    test_random_phase(1'b1, 12'd30, 8'd5, 3, 150);
    test_random_phase(1'b1, 12'd2048, 8'd0, 0, 120);

    // let any stray result show up before the verdict
    wait_drained();
    repeat (60) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire
